// ----- rtl/core/user_id_field_splitter_defines.svh -----
// Assertion macros used by the parser RTL of the user-ID field splitter.
// Expects signals named clock and reset in the including module.
`ifndef USER_ID_FIELD_SPLITTER_DEFINES_SVH
`define USER_ID_FIELD_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define UIDFS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uidfs same-cycle check failed");

// Next-cycle implication, disabled during reset
`define UIDFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uidfs next-cycle check failed");

`endif

// ----- rtl/core/uidfs_pkg.sv -----
// Shared types and constants of the user-ID field splitter.
// No dependencies; used by the interfaces, the parser and the top level.
package uidfs_pkg;

   // Longest string content that is parsed
   localparam int MAX_LEN = 256;
   localparam int POS_W   = $clog2(MAX_LEN + 1);   // byte counter, holds MAX_LEN
   localparam int SPOS_W  = $clog2(MAX_LEN);       // position of a parsed byte
   localparam int LEN_W   = POS_W;                 // span length, up to MAX_LEN
   localparam int DEPTH_W = POS_W;                 // nesting depth

   // Field slots
   localparam int NUM_FIELDS  = 3;
   localparam int FLD_NAME    = 0;
   localparam int FLD_EMAIL   = 1;
   localparam int FLD_COMMENT = 2;

   // Character codes
   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_BLANK_HI = 8'h0D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_LT       = 8'h3C;
   localparam logic [7:0] CH_GT       = 8'h3E;
   localparam logic [7:0] CH_LPAREN   = 8'h28;
   localparam logic [7:0] CH_RPAREN   = 8'h29;

   // One parse step handed to the parser
   typedef struct packed {
      logic       adv;
      logic [7:0] char_byte;
      logic       last_byte;
   } uidfs_step_type;

   // One result item
   typedef struct packed {
      logic [SPOS_W-1:0] name_start;
      logic [LEN_W-1:0]  name_len;
      logic [SPOS_W-1:0] email_start;
      logic [LEN_W-1:0]  email_len;
      logic [SPOS_W-1:0] comment_start;
      logic [LEN_W-1:0]  comment_len;
      logic              too_long;
   } uidfs_result_type;

endpackage

// ----- rtl/core/uidfs_ifs.sv -----
// Valid/ready channel interfaces of the user-ID field splitter.
// Depends on uidfs_pkg for field widths.
interface uidfs_req_if import uidfs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       last_byte;

   modport source (output valid, output char_byte, output last_byte, input ready);
   modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface uidfs_rsp_if import uidfs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SPOS_W-1:0] name_start;
   logic [LEN_W-1:0]  name_len;
   logic [SPOS_W-1:0] email_start;
   logic [LEN_W-1:0]  email_len;
   logic [SPOS_W-1:0] comment_start;
   logic [LEN_W-1:0]  comment_len;
   logic              too_long;

   modport source (output valid, output name_start, output name_len, output email_start,
                   output email_len, output comment_start, output comment_len,
                   output too_long, input ready);
   modport sink   (input valid, input name_start, input name_len, input email_start,
                   input email_len, input comment_start, input comment_len,
                   input too_long, output ready);
endinterface

// ----- rtl/core/uidfs_parse.sv -----
// Parser state and per-byte update of the user-ID field splitter.
// Depends on uidfs_pkg and user_id_field_splitter_defines.svh.
`include "user_id_field_splitter_defines.svh"

module uidfs_parse import uidfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  uidfs_step_type   step,
   output uidfs_result_type result
);

   logic [POS_W-1:0]   byte_pos_ff,   byte_pos_in;
   logic               inside_ff,     inside_in;
   logic [DEPTH_W-1:0] angle_depth_ff, angle_depth_in;
   logic [DEPTH_W-1:0] paren_depth_ff, paren_depth_in;
   logic [SPOS_W-1:0]  first_ff,      first_in;
   logic [SPOS_W-1:0]  last_ff,       last_in;
   logic               has_ff,        has_in;
   logic               ended_ff,      ended_in;
   logic               ovf_ff,        ovf_in;
   logic [NUM_FIELDS-1:0] cap_ff,     cap_in;
   logic [SPOS_W-1:0]  start_ff [NUM_FIELDS];
   logic [SPOS_W-1:0]  start_in [NUM_FIELDS];
   logic [LEN_W-1:0]   len_ff   [NUM_FIELDS];
   logic [LEN_W-1:0]   len_in   [NUM_FIELDS];

   // Trimmed span of the current segment
   logic [SPOS_W-1:0] seg_start;
   logic [LEN_W-1:0]  seg_len;

   assign seg_start = has_ff ? first_ff : '0;
   assign seg_len   = has_ff ? (LEN_W'(last_ff) - LEN_W'(first_ff) + LEN_W'(1)) : '0;

   // Per-byte update
   always_comb begin
      logic [7:0]        c;
      logic [SPOS_W-1:0] pos;
      logic              restart;
      logic              blank;
      c       = step.char_byte;
      pos     = byte_pos_ff[SPOS_W-1:0];
      restart = 1'b0;
      blank   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_BLANK_HI);

      byte_pos_in    = byte_pos_ff;
      inside_in      = inside_ff;
      angle_depth_in = angle_depth_ff;
      paren_depth_in = paren_depth_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      has_in         = has_ff;
      ended_in       = ended_ff;
      ovf_in         = ovf_ff;
      cap_in         = cap_ff;
      start_in       = start_ff;
      len_in         = len_ff;

      if (step.adv && !ended_ff) begin
         if (c == CH_NUL) begin
            ended_in = 1'b1;
         end else if (byte_pos_ff >= POS_W'(MAX_LEN)) begin
            ovf_in = 1'b1;
         end else begin
            priority if (angle_depth_ff != '0) begin
               if (c == CH_LT) begin
                  angle_depth_in = angle_depth_ff + DEPTH_W'(1);
               end else if (c == CH_GT) begin
                  angle_depth_in = angle_depth_ff - DEPTH_W'(1);
                  if (angle_depth_ff == DEPTH_W'(1) && !cap_ff[FLD_EMAIL]) begin
                     cap_in[FLD_EMAIL]   = 1'b1;
                     start_in[FLD_EMAIL] = seg_start;
                     len_in[FLD_EMAIL]   = seg_len;
                     restart             = 1'b1;
                  end
               end
            end else if (paren_depth_ff != '0) begin
               if (c == CH_LPAREN) begin
                  paren_depth_in = paren_depth_ff + DEPTH_W'(1);
               end else if (c == CH_RPAREN) begin
                  paren_depth_in = paren_depth_ff - DEPTH_W'(1);
                  if (paren_depth_ff == DEPTH_W'(1) && !cap_ff[FLD_COMMENT]) begin
                     cap_in[FLD_COMMENT]   = 1'b1;
                     start_in[FLD_COMMENT] = seg_start;
                     len_in[FLD_COMMENT]   = seg_len;
                     restart               = 1'b1;
                  end
               end
            end else if (c == CH_LT || c == CH_LPAREN) begin
               // a pending name ends here; '<' outside a name restarts the segment
               if (inside_ff) begin
                  if (!cap_ff[FLD_NAME]) begin
                     cap_in[FLD_NAME]   = 1'b1;
                     start_in[FLD_NAME] = seg_start;
                     len_in[FLD_NAME]   = seg_len;
                     restart            = 1'b1;
                  end
               end else if (c == CH_LT) begin
                  restart = 1'b1;
               end
               inside_in = 1'b0;
               if (c == CH_LT) begin
                  angle_depth_in = DEPTH_W'(1);
               end else begin
                  paren_depth_in = DEPTH_W'(1);
               end
            end else begin
               if (!inside_ff && c != CH_SPACE && c != CH_TAB) begin
                  inside_in = 1'b1;
               end
            end

            // segment trim tracking
            if (restart) begin
               has_in = 1'b0;
            end else if (!blank) begin
               if (!has_ff) begin
                  first_in = pos;
               end
               last_in = pos;
               has_in  = 1'b1;
            end
            byte_pos_in = byte_pos_ff + POS_W'(1);
         end
      end

      // Result from the post-byte state, with a pending name closed out
      result.too_long      = ovf_in;
      result.email_start   = start_in[FLD_EMAIL];
      result.email_len     = len_in[FLD_EMAIL];
      result.comment_start = start_in[FLD_COMMENT];
      result.comment_len   = len_in[FLD_COMMENT];
      result.name_start    = start_in[FLD_NAME];
      result.name_len      = len_in[FLD_NAME];
      if (inside_in && !cap_in[FLD_NAME]) begin
         result.name_start = has_in ? first_in : '0;
         result.name_len   = has_in ? (LEN_W'(last_in) - LEN_W'(first_in) + LEN_W'(1)) : '0;
      end

      // end of string: back to the idle state
      if (step.adv && step.last_byte) begin
         byte_pos_in    = '0;
         inside_in      = 1'b0;
         angle_depth_in = '0;
         paren_depth_in = '0;
         first_in       = '0;
         last_in        = '0;
         has_in         = 1'b0;
         ended_in       = 1'b0;
         ovf_in         = 1'b0;
         cap_in         = '0;
         for (int k = 0; k < NUM_FIELDS; k++) begin
            start_in[k] = '0;
            len_in[k]   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff    <= '0;
         inside_ff      <= 1'b0;
         angle_depth_ff <= '0;
         paren_depth_ff <= '0;
         first_ff       <= '0;
         last_ff        <= '0;
         has_ff         <= 1'b0;
         ended_ff       <= 1'b0;
         ovf_ff         <= 1'b0;
         cap_ff         <= '0;
         for (int k = 0; k < NUM_FIELDS; k++) begin
            start_ff[k] <= '0;
            len_ff[k]   <= '0;
         end
      end else begin
         byte_pos_ff    <= byte_pos_in;
         inside_ff      <= inside_in;
         angle_depth_ff <= angle_depth_in;
         paren_depth_ff <= paren_depth_in;
         first_ff       <= first_in;
         last_ff        <= last_in;
         has_ff         <= has_in;
         ended_ff       <= ended_in;
         ovf_ff         <= ovf_in;
         cap_ff         <= cap_in;
         start_ff       <= start_in;
         len_ff         <= len_in;
      end
   end

   `UIDFS_ASSERT_NOW(a_depth_excl, 1'b1, (angle_depth_ff == '0) || (paren_depth_ff == '0))
   `UIDFS_ASSERT_NOW(a_pos_bound, 1'b1, byte_pos_ff <= POS_W'(MAX_LEN))
   `UIDFS_ASSERT_NEXT(a_clear_after_last, step.adv && step.last_byte,
                      (byte_pos_ff == '0) && !ended_ff && (cap_ff == '0) && !ovf_ff)

endmodule

// ----- rtl/core/user_id_field_splitter.sv -----
// Path: an accepted last byte is held in the input register; its result item goes to the result register once free.
// Throughput: one byte item per cycle, save that a last byte waits in the input
// register while a result is stalled, and then req ready drops.
// Reset: synchronous, active high; clears the parser state and both valid flags.
// Top level of the user-ID field splitter; depends on uidfs_pkg, the channel
// interfaces in uidfs_ifs.sv and the parser uidfs_parse.
module user_id_field_splitter import uidfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   uidfs_req_if.sink          req_ch,
   uidfs_rsp_if.source        rsp_ch
);

   logic             s1_valid_ff, s1_valid_in;
   logic [7:0]       s1_char_ff;
   logic             s1_last_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   uidfs_result_type rsp_data_ff;
   uidfs_result_type parse_result;
   uidfs_step_type   step;
   logic             out_free;
   logic             s1_adv;
   logic             req_take;

   // Handshake: a non-last byte never waits on the output side
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_take = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = (s1_adv && s1_last_ff) || (rsp_valid_ff && !rsp_ch.ready);

   assign step.adv       = s1_adv;
   assign step.char_byte = s1_char_ff;
   assign step.last_byte = s1_last_ff;

   uidfs_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .result (parse_result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_char_ff <= req_ch.char_byte;
         s1_last_ff <= req_ch.last_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_adv && s1_last_ff) begin
         rsp_data_ff <= parse_result;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.name_start    = rsp_data_ff.name_start;
   assign rsp_ch.name_len      = rsp_data_ff.name_len;
   assign rsp_ch.email_start   = rsp_data_ff.email_start;
   assign rsp_ch.email_len     = rsp_data_ff.email_len;
   assign rsp_ch.comment_start = rsp_data_ff.comment_start;
   assign rsp_ch.comment_len   = rsp_data_ff.comment_len;
   assign rsp_ch.too_long      = rsp_data_ff.too_long;

endmodule
